### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; clk and arst_n are taken from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RME_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/rme_pkg.sv
// Package for the RSA modular exponentiation block: widths, codes and the control program.
`default_nettype none

package rme_pkg;

	localparam int CIPHER_W         = 32;
	localparam int PLAIN_W          = 32;
	localparam int BYTE_W           = 8;
	localparam int CFG_W            = 32;
	localparam int MODULUS_BITS_DEF = 32;
	localparam int CNT_W            = $clog2(CIPHER_W);
	localparam int PC_W             = 4;

	// Register indexes of the write port.
	typedef enum logic [0:0] {
		REG_MODULUS  = 1'b0,
		REG_EXPONENT = 1'b1
	} cfg_idx_t;

	// Datapath operation of one control word.
	typedef enum logic [3:0] {
		MOP_NOP,
		MOP_WAIT,
		MOP_MSTEP,
		MOP_SETBASE,
		MOP_LDSQ,
		MOP_LDMUL,
		MOP_ACCW,
		MOP_ESHIFT,
		MOP_RES,
		MOP_ZERO,
		MOP_HI,
		MOP_LO
	} mop_t;

	// Jump condition of one control word.
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_MSMALL,
		C_CNT_NZ,
		C_EBIT0,
		C_ECNT_NZ,
		C_OUT_BUSY,
		C_LO_ZERO
	} cond_t;

	typedef struct packed {
		mop_t            op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	// Program addresses.
	localparam logic [PC_W-1:0] P_WAIT  = 4'd0;
	localparam logic [PC_W-1:0] P_CHK   = 4'd1;
	localparam logic [PC_W-1:0] P_RED   = 4'd2;
	localparam logic [PC_W-1:0] P_BASE  = 4'd3;
	localparam logic [PC_W-1:0] P_LDSQ  = 4'd4;
	localparam logic [PC_W-1:0] P_SQL   = 4'd5;
	localparam logic [PC_W-1:0] P_SQD   = 4'd6;
	localparam logic [PC_W-1:0] P_LDML  = 4'd7;
	localparam logic [PC_W-1:0] P_MLL   = 4'd8;
	localparam logic [PC_W-1:0] P_MLD   = 4'd9;
	localparam logic [PC_W-1:0] P_NEXT  = 4'd10;
	localparam logic [PC_W-1:0] P_DONE  = 4'd11;
	localparam logic [PC_W-1:0] P_ZERO  = 4'd12;
	localparam logic [PC_W-1:0] P_HI    = 4'd13;
	localparam logic [PC_W-1:0] P_LOCHK = 4'd14;
	localparam logic [PC_W-1:0] P_EMLO  = 4'd15;

	function automatic ucode_t uc(input mop_t op, input cond_t cond,
			input logic [PC_W-1:0] target);
		ucode_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// Control program; the last word falls through to the wait word by wrap-around.
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
		ucode_t w;
		case (addr)
			P_WAIT:  w = uc(MOP_WAIT,    C_NO_REQ,   P_WAIT);
			P_CHK:   w = uc(MOP_NOP,     C_MSMALL,   P_ZERO);
			P_RED:   w = uc(MOP_MSTEP,   C_CNT_NZ,   P_RED);
			P_BASE:  w = uc(MOP_SETBASE, C_NEVER,    P_WAIT);
			P_LDSQ:  w = uc(MOP_LDSQ,    C_NEVER,    P_WAIT);
			P_SQL:   w = uc(MOP_MSTEP,   C_CNT_NZ,   P_SQL);
			P_SQD:   w = uc(MOP_ACCW,    C_EBIT0,    P_NEXT);
			P_LDML:  w = uc(MOP_LDMUL,   C_NEVER,    P_WAIT);
			P_MLL:   w = uc(MOP_MSTEP,   C_CNT_NZ,   P_MLL);
			P_MLD:   w = uc(MOP_ACCW,    C_NEVER,    P_WAIT);
			P_NEXT:  w = uc(MOP_ESHIFT,  C_ECNT_NZ,  P_LDSQ);
			P_DONE:  w = uc(MOP_RES,     C_ALWAYS,   P_HI);
			P_ZERO:  w = uc(MOP_ZERO,    C_NEVER,    P_WAIT);
			P_HI:    w = uc(MOP_HI,      C_OUT_BUSY, P_HI);
			P_LOCHK: w = uc(MOP_NOP,     C_LO_ZERO,  P_WAIT);
			P_EMLO:  w = uc(MOP_LO,      C_OUT_BUSY, P_EMLO);
			default: w = uc(MOP_NOP,     C_ALWAYS,   P_WAIT);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/rme_ifs.sv
// Channel interfaces: ciphertext requests in, plaintext byte requests out.
`default_nettype none

interface rme_cipher_if import rme_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CIPHER_W-1:0] cipher_value;

	modport source (output valid, output cipher_value, input ready);
	modport sink   (input valid, input cipher_value, output ready);
endinterface

interface rme_result_if import rme_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  out_byte;
	logic               last;
	logic [PLAIN_W-1:0] plain_value;

	modport source (output valid, output out_byte, output last, output plain_value, input ready);
	modport sink   (input valid, input out_byte, input last, input plain_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/rsa_modexp_decrypt.sv
// RSA decryption core: plaintext = cipher^exponent mod modulus, delivered as bytes.
//
// Usage:
//   Write the modulus (index REG_MODULUS) and exponent (index REG_EXPONENT)
//   on the wr_en/wr_index/wr_data port while the core is idle. Both hold
//   MODULUS_BITS bits (at most 32). Reset leaves modulus = 2, exponent = 1.
//   Send one ciphertext request on the cipher channel (valid/ready). The
//   core answers on the result channel with bits 15:8 of the plaintext,
//   then bits 7:0 only if they are nonzero; last marks the final byte and
//   plain_value carries the full result on every byte.
// Operation:
//   A microcoded sequencer runs one shared bit-serial modular multiplier,
//   one multiplier bit per cycle. After the request is taken it reduces
//   the ciphertext mod the modulus, then squares for every exponent bit
//   and multiplies for every set bit, then loads the first byte; with a
//   modulus below 2 it loads a zero byte instead.
//   One request is worked at a time.
// Stalls: the result sits in an output register; a stalled receiver holds
//   the sequencer at the emit step, but once the last byte is loaded a new
//   request is taken while that byte still waits. Reset clears the
//   sequencer and drops any byte in flight.
`default_nettype none

`include "assert_macros.svh"

module rsa_modexp_decrypt import rme_pkg::*; #(
	parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  cfg_idx_t         wr_index,
	input  logic [CFG_W-1:0] wr_data,
	rme_cipher_if.sink       cipher,
	rme_result_if.source     result
);

	// Working width: registers are kept to at most 32 bits.
	localparam int DW = (MODULUS_BITS < CIPHER_W) ? MODULUS_BITS : CIPHER_W;
	// Width of the multiplier step sum plus a sign bit for the trial subtracts.
	localparam int SW = DW + 3;

	logic [PC_W-1:0]     pc_q;
	logic [PC_W-1:0]     pc_d;
	ucode_t              uw;
	logic                cond_hit;

	logic [DW-1:0]       m_q;
	logic [DW-1:0]       e_q;
	logic [DW-1:0]       base_q;
	logic [DW-1:0]       acc_q;
	logic [DW-1:0]       prod_q;
	logic [DW-1:0]       opa_q;
	logic [DW-1:0]       esh_q;
	logic [CIPHER_W-1:0] opb_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    ecnt_q;
	logic [PLAIN_W-1:0]  res_q;

	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                out_last_q;
	logic [PLAIN_W-1:0]  out_plain_q;

	logic                in_acc;
	logic                out_busy;
	logic                emit;

	logic [SW-1:0]       sum_w;
	logic [SW-1:0]       dif1_w;
	logic [SW-1:0]       dif2_w;
	logic [DW-1:0]       step_res;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= DW'(2);
			e_q <= DW'(1);
		end else if (wr_en) begin
			case (wr_index)
				REG_MODULUS:  m_q <= wr_data[DW-1:0];
				REG_EXPONENT: e_q <= wr_data[DW-1:0];
				default:      ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequencer: fetch the control word, evaluate its jump condition
	// ---------------------------------------------------------------
	assign uw       = ucode_rom(pc_q);
	assign in_acc   = cipher.valid && cipher.ready;
	assign out_busy = out_valid_q && !result.ready;

	always_comb begin
		case (uw.cond)
			C_NEVER:    cond_hit = 1'b0;
			C_ALWAYS:   cond_hit = 1'b1;
			C_NO_REQ:   cond_hit = !cipher.valid;
			C_MSMALL:   cond_hit = (m_q < DW'(2));
			C_CNT_NZ:   cond_hit = (cnt_q != '0);
			C_EBIT0:    cond_hit = !esh_q[DW-1];
			C_ECNT_NZ:  cond_hit = (ecnt_q != '0);
			C_OUT_BUSY: cond_hit = out_busy;
			C_LO_ZERO:  cond_hit = (res_q[BYTE_W-1:0] == '0);
			default:    cond_hit = 1'b0;
		endcase
		// Fall through by increment; the last word wraps back to the wait word.
		pc_d = cond_hit ? uw.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign cipher.ready = (uw.op == MOP_WAIT);

	// ---------------------------------------------------------------
	// Bit-serial modular multiplier step: prod = (2*prod + bit*opa) mod m.
	// The sum is below 3m, so subtract m or 2m in parallel and pick.
	// ---------------------------------------------------------------
	always_comb begin
		sum_w  = SW'({prod_q, 1'b0}) + (opb_q[CIPHER_W-1] ? SW'(opa_q) : SW'(0));
		dif1_w = sum_w - SW'(m_q);
		dif2_w = sum_w - SW'({m_q, 1'b0});
		if (!dif2_w[SW-1]) begin
			step_res = dif2_w[DW-1:0];
		end else if (!dif1_w[SW-1]) begin
			step_res = dif1_w[DW-1:0];
		end else begin
			step_res = sum_w[DW-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Datapath registers driven by the control word
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (uw.op)
			MOP_WAIT: begin
				// Base reduction is a product 1 * cipher, fed a cipher bit per step.
				if (in_acc) begin
					opa_q  <= DW'(1);
					opb_q  <= cipher.cipher_value;
					prod_q <= '0;
					cnt_q  <= CNT_W'(CIPHER_W - 1);
				end
			end
			MOP_MSTEP: begin
				prod_q <= step_res;
				opb_q  <= opb_q << 1;
				cnt_q  <= cnt_q - 1'b1;
			end
			MOP_SETBASE: begin
				base_q <= prod_q;
				acc_q  <= DW'(1);
				esh_q  <= e_q;
				ecnt_q <= CNT_W'(DW - 1);
			end
			MOP_LDSQ: begin
				opa_q  <= acc_q;
				opb_q  <= CIPHER_W'(acc_q) << (CIPHER_W - DW);
				prod_q <= '0;
				cnt_q  <= CNT_W'(DW - 1);
			end
			MOP_LDMUL: begin
				opa_q  <= acc_q;
				opb_q  <= CIPHER_W'(base_q) << (CIPHER_W - DW);
				prod_q <= '0;
				cnt_q  <= CNT_W'(DW - 1);
			end
			MOP_ACCW: begin
				acc_q <= prod_q;
			end
			MOP_ESHIFT: begin
				esh_q  <= esh_q << 1;
				ecnt_q <= ecnt_q - 1'b1;
			end
			MOP_RES: begin
				res_q <= PLAIN_W'(acc_q);
			end
			MOP_ZERO: begin
				res_q <= '0;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// Output register: load a byte when the slot is free, drop on take
	// ---------------------------------------------------------------
	assign emit = ((uw.op == MOP_HI) || (uw.op == MOP_LO)) && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (uw.op == MOP_HI) begin
				out_byte_q  <= res_q[2*BYTE_W-1:BYTE_W];
				out_last_q  <= (res_q[BYTE_W-1:0] == '0);
				out_plain_q <= res_q;
			end else begin
				out_byte_q <= res_q[BYTE_W-1:0];
				out_last_q <= 1'b1;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_byte    = out_byte_q;
	assign result.last        = out_last_q;
	assign result.plain_value = out_plain_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`RME_ASSERT_NOW(a_prod_reduced, uw.op == MOP_MSTEP, prod_q < m_q, "product left modulus range")
	`RME_ASSERT_NOW(a_base_reduced, uw.op == MOP_RES, (base_q < m_q) && (acc_q < m_q), "base or accumulator not reduced")
	`RME_ASSERT_NOW(a_first_not_last, result.valid && !result.last, result.plain_value[BYTE_W-1:0] != '0, "high byte not last with zero low byte")
	`RME_ASSERT_NEXT(a_hold_stalled, out_valid_q && !result.ready, out_valid_q, "stalled byte dropped")

endmodule

`default_nettype wire
